>>> rtl/lss_pkg.sv
// Shared opcodes, status codes and cell control type for the searchable stack.
package lss_pkg;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned CNT_W  = 5;

   typedef struct packed {
      logic push;
      logic pop;
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

>>> rtl/lss_cell.sv
// One stack cell: holds an entry and a search hit bit, shifts with its neighbors.
module lss_cell (
   input  logic                        clock,
   input  lss_pkg::cell_ctrl_type      ctrl,
   input  logic                        occupied,
   input  logic [lss_pkg::WORD_W-1:0]  key,
   input  logic [lss_pkg::WORD_W-1:0]  above_entry,
   input  logic [lss_pkg::WORD_W-1:0]  below_entry,
   input  logic                        below_hit,
   output logic [lss_pkg::WORD_W-1:0]  entry,
   output logic                        hit
);
   import lss_pkg::*;

   logic [WORD_W-1:0] entry_ff;
   logic [WORD_W-1:0] entry_in;
   logic              hit_ff;
   logic              hit_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         entry_in = above_entry;
      end else if (ctrl.pop) begin
         entry_in = below_entry;
      end
   end

   always_comb begin
      hit_in = hit_ff;
      if (ctrl.load) begin
         hit_in = occupied && (entry_ff == key);
      end else if (ctrl.shift) begin
         hit_in = below_hit;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

>>> rtl/lifo_stack_with_search.sv
// Top level: bounded LIFO stack built from a chain of cells, with linear search.
//
// Usage: drive req_opcode and req_value with start high; the beat is taken
// at a clock edge where start is high and busy is low. Each beat yields one
// result beat, shown for one cycle with rsp_strobe high; the receiver cannot
// stall it. Push, pop and unused opcodes answer in the cycle after the beat and
// busy stays low, so such beats can follow every cycle. Cell 0 is the top;
// a push shifts every entry down one cell, a pop shifts them up.
// A search latches a hit bit in every occupied cell in the accept cycle, then
// the hit bits shift toward the top one cell per cycle until a hit reaches
// cell 0 or the occupied depth is used up. A search on a non-empty stack
// answers when that scan ends, so a match nearer the top answers sooner;
// on an empty stack it answers in the cycle after the beat. Busy is high
// for the scan cycles. Position and occupancy are reported modulo 32.
// Reset (synchronous, active high) empties the stack and clears the scan;
// entry contents are not cleared.
module lifo_stack_with_search #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_opcode,
   input  logic signed [lss_pkg::WORD_W-1:0] req_value,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_found,
   output logic [lss_pkg::CNT_W-1:0]   rsp_position,
   output logic [lss_pkg::CNT_W-1:0]   rsp_occupancy
);
   import lss_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         step_ff;
   logic                  rsp_strobe_ff;
   logic [1:0]            rsp_status_ff;
   logic                  rsp_found_ff;
   logic [CNT_W-1:0]      rsp_position_ff;

   logic                  accept;
   logic                  full;
   logic                  empty;
   cell_ctrl_type         ctrl;
   logic [WORD_W-1:0]     entry_w [DEPTH];
   logic                  hit_w   [DEPTH];
   logic [31:0]           count_wide;
   logic [31:0]           pos_wide;

   assign busy   = (state_ff == S_SCAN);
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   assign ctrl.push  = accept && (req_opcode == OP_PUSH) && !full;
   assign ctrl.pop   = accept && (req_opcode == OP_POP) && !empty;
   assign ctrl.load  = accept && (req_opcode == OP_SEARCH);
   assign ctrl.shift = (state_ff == S_SCAN);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] above;
      logic [WORD_W-1:0] below;
      logic              below_hit;
      if (i == 0) begin : g_top
         assign above = req_value;
      end else begin : g_mid
         assign above = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_bot
         assign below     = '0;
         assign below_hit = 1'b0;
      end else begin : g_up
         assign below     = entry_w[i+1];
         assign below_hit = hit_w[i+1];
      end
      lss_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CW'(i) < count_ff),
         .key         (req_value),
         .above_entry (above),
         .below_entry (below),
         .below_hit   (below_hit),
         .entry       (entry_w[i]),
         .hit         (hit_w[i])
      );
   end

   assign pos_wide = 32'(step_ff) + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         step_ff         <= '0;
         rsp_strobe_ff   <= 1'b0;
         rsp_status_ff   <= ST_OK;
         rsp_found_ff    <= 1'b0;
         rsp_position_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_found_ff    <= 1'b0;
                  rsp_position_ff <= '0;
                  case (req_opcode)
                     OP_PUSH: begin
                        rsp_strobe_ff <= 1'b1;
                        if (full) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           rsp_status_ff <= ST_OK;
                           count_ff      <= count_ff + CW'(1);
                        end
                     end
                     OP_POP: begin
                        rsp_strobe_ff <= 1'b1;
                        if (empty) begin
                           rsp_status_ff <= ST_EMPTY;
                        end else begin
                           rsp_status_ff <= ST_OK;
                           count_ff      <= count_ff - CW'(1);
                        end
                     end
                     OP_SEARCH: begin
                        rsp_status_ff <= ST_OK;
                        if (empty) begin
                           rsp_strobe_ff <= 1'b1;
                        end else begin
                           rsp_strobe_ff <= 1'b0;
                           step_ff       <= '0;
                           state_ff      <= S_SCAN;
                        end
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_status_ff <= ST_OK;
                     end
                  endcase
               end else begin
                  rsp_strobe_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               if (hit_w[0]) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_found_ff    <= 1'b1;
                  rsp_position_ff <= pos_wide[CNT_W-1:0];
                  state_ff        <= S_IDLE;
               end else if (pos_wide == 32'(count_ff)) begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  rsp_strobe_ff <= 1'b0;
                  step_ff       <= step_ff + CW'(1);
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= S_IDLE;
            end
         endcase
      end
   end

   assign count_wide    = 32'(count_ff);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_occupancy = count_wide[CNT_W-1:0];

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (count_ff != '0))
      else $error("scan running on an empty stack");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (step_ff < count_ff))
      else $error("scan went past the occupied depth");

   a_quick_reply: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode != OP_SEARCH)) |=> rsp_strobe)
      else $error("push or pop beat got no reply in the next cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> ($past(state_ff) == S_SCAN))
      else $error("match reported without a scan");

endmodule

>>> tb/lifo_stack_with_search_checker.sv
// Checker for the searchable LIFO stack: predicts each result beat and compares it.
module lifo_stack_with_search_checker #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [1:0]                        req_opcode,
   input  logic signed [lss_pkg::WORD_W-1:0] req_value,
   input  logic                              rsp_strobe,
   input  logic [1:0]                        rsp_status,
   input  logic                              rsp_found,
   input  logic [lss_pkg::CNT_W-1:0]         rsp_position,
   input  logic [lss_pkg::CNT_W-1:0]         rsp_occupancy,
   output int                                error_count,
   output int                                pending,
   output int                                results_seen,
   output int                                search_hits,
   output int                                full_drops,
   output int                                empty_pops
);

   import lss_pkg::*;

   typedef struct packed {
      logic [1:0]       status;
      logic             found;
      logic [CNT_W-1:0] position;
      logic [CNT_W-1:0] occupancy;
   } stack_rsp_type;

   logic signed [WORD_W-1:0] shadow_entries [DEPTH];
   int unsigned              shadow_count;
   stack_rsp_type            rsp_expected_q [$];

   int err_n  = 0;
   int seen_n = 0;
   int hit_n  = 0;
   int full_n = 0;
   int empty_n = 0;

   // Applies one operation to the shadow stack and returns its result.
   function automatic stack_rsp_type stack_apply(input logic [1:0] op,
                                                 input logic signed [WORD_W-1:0] val);
      stack_rsp_type r;
      int unsigned   k;
      logic          hit;
      r   = '0;
      hit = 1'b0;
      case (op)
         OP_PUSH: begin
            if (shadow_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_entries[shadow_count] = val;
               shadow_count++;
            end
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_count--;
            end
         end
         OP_SEARCH: begin
            for (k = 0; k < shadow_count; k++) begin
               if (!hit && shadow_entries[shadow_count - 1 - k] == val) begin
                  hit        = 1'b1;
                  r.found    = 1'b1;
                  r.position = CNT_W'(k + 1);
               end
            end
         end
         default: ;
      endcase
      r.occupancy = CNT_W'(shadow_count);
      return r;
   endfunction

   always @(posedge clock) begin
      stack_rsp_type want;
      if (reset) begin
         shadow_count = 0;
         rsp_expected_q.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            seen_n++;
            if (rsp_expected_q.size() == 0) begin
               err_n++;
               $error("result beat with no operation outstanding");
            end else begin
               want = rsp_expected_q.pop_front();
               if (rsp_status !== want.status) begin
                  err_n++;
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
               end
               if (rsp_found !== want.found) begin
                  err_n++;
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
               end
               if (rsp_position !== want.position) begin
                  err_n++;
                  $error("position: expected %0d, got %0d", want.position, rsp_position);
               end
               if (rsp_occupancy !== want.occupancy) begin
                  err_n++;
                  $error("occupancy: expected %0d, got %0d", want.occupancy,
                         rsp_occupancy);
               end
            end
         end else if (rsp_strobe !== 1'b0) begin
            err_n++;
            $error("rsp_strobe: expected 0 or 1, got %b", rsp_strobe);
         end
         if (start === 1'b1 && busy === 1'b0) begin
            want = stack_apply(req_opcode, req_value);
            if (req_opcode == OP_SEARCH && want.found) hit_n++;
            if (want.status == ST_FULL) full_n++;
            if (want.status == ST_EMPTY) empty_n++;
            rsp_expected_q.push_back(want);
         end else if (start === 1'b1 && busy !== 1'b1) begin
            err_n++;
            $error("busy: expected 0 or 1, got %b", busy);
         end
      end
      error_count  <= err_n;
      pending      <= rsp_expected_q.size();
      results_seen <= seen_n;
      search_hits  <= hit_n;
      full_drops   <= full_n;
      empty_pops   <= empty_n;
   end

endmodule

>>> tb/lifo_stack_with_search_tb.sv
// Testbench top for the searchable LIFO stack: drives operation beats and reports the verdict.
module lifo_stack_with_search_tb;

   import lss_pkg::*;

   localparam int unsigned DEPTH       = 16;
   localparam logic [1:0]  OP_NONE     = 2'd3;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASE_BEATS = 250;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_opcode;
   logic signed [WORD_W-1:0] req_value;
   logic                     rsp_strobe;
   logic [1:0]               rsp_status;
   logic                     rsp_found;
   logic [CNT_W-1:0]         rsp_position;
   logic [CNT_W-1:0]         rsp_occupancy;

   int error_count;
   int pending;
   int results_seen;
   int search_hits;
   int full_drops;
   int empty_pops;

   int                       cycle_count = 0;
   int                       idle_pct;
   int                       beats_sent = 0;
   logic signed [WORD_W-1:0] recent_values [$];

   lifo_stack_with_search #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_position  (rsp_position),
      .rsp_occupancy (rsp_occupancy)
   );

   lifo_stack_with_search_checker #(.DEPTH(DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_position  (rsp_position),
      .rsp_occupancy (rsp_occupancy),
      .error_count   (error_count),
      .pending       (pending),
      .results_seen  (results_seen),
      .search_hits   (search_hits),
      .full_drops    (full_drops),
      .empty_pops    (empty_pops)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Presents one beat, idling the sender cycle by cycle first, and waits for acceptance.
   task automatic send_beat(input logic [1:0] op, input logic signed [WORD_W-1:0] val);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      do @(posedge clock); while (busy !== 1'b0);
      beats_sent++;
      if (op == OP_PUSH) begin
         recent_values.push_back(val);
         if (recent_values.size() > 24) void'(recent_values.pop_front());
      end
   endtask

   function automatic logic signed [WORD_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 12) begin
         case ($urandom_range(4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
         endcase
      end
      if (r < 60 && recent_values.size() > 0)
         return recent_values[$urandom_range(recent_values.size() - 1)];
      return $urandom;
   endfunction

   // Bursts lean toward filling, draining or mixing so both bounds are reached often.
   task automatic random_phase(input int n_beats);
      int         bias;
      int         r;
      logic [1:0] op;
      for (int i = 0; i < n_beats; i++) begin
         if (i % 30 == 0) bias = $urandom_range(2);
         r = $urandom_range(99);
         case (bias)
            0:       op = (r < 60) ? OP_PUSH : (r < 72) ? OP_POP : (r < 96) ? OP_SEARCH : OP_NONE;
            1:       op = (r < 15) ? OP_PUSH : (r < 65) ? OP_POP : (r < 96) ? OP_SEARCH : OP_NONE;
            default: op = (r < 35) ? OP_PUSH : (r < 60) ? OP_POP : (r < 96) ? OP_SEARCH : OP_NONE;
         endcase
         send_beat(op, (op == OP_POP && $urandom_range(1)) ? $urandom : pick_value());
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_opcode = OP_PUSH;
      req_value  = '0;
      idle_pct   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-stack cases, extremes, nearest duplicate, full stack, deepest hit
      send_beat(OP_SEARCH, 32'sd5);
      send_beat(OP_POP, 32'sd0);
      send_beat(OP_NONE, -32'sd1);
      send_beat(OP_PUSH, 32'sh8000_0000);
      send_beat(OP_PUSH, 32'sh7FFF_FFFF);
      send_beat(OP_PUSH, 32'sd0);
      send_beat(OP_PUSH, -32'sd1);
      send_beat(OP_PUSH, 32'sh7FFF_FFFF);
      send_beat(OP_SEARCH, 32'sh7FFF_FFFF);
      send_beat(OP_SEARCH, 32'sh8000_0000);
      send_beat(OP_SEARCH, 32'sd12345);
      send_beat(OP_NONE, 32'sh7FFF_FFFF);
      send_beat(OP_POP, 32'sh7FFF_FFFF);
      send_beat(OP_SEARCH, 32'sh7FFF_FFFF);
      for (int i = 0; i < 12; i++) send_beat(OP_PUSH, 32'sh5555_0000 + i);
      send_beat(OP_PUSH, 32'sh2AAA_AAAA);
      send_beat(OP_SEARCH, 32'sh8000_0000);

      idle_pct = 25;
      random_phase(PHASE_BEATS);
      idle_pct = 65;
      random_phase(PHASE_BEATS);
      idle_pct = 0;
      random_phase(PHASE_BEATS);
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      $display("%0d beats sent, %0d results checked over %0d cycles", beats_sent,
               results_seen, cycle_count);
      $display("%0d search hits, %0d pushes refused when full, %0d pops on empty",
               search_hits, full_drops, empty_pops);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
